// ===== design/gbkt_pkg.sv =====
// Shared types and constants for the gyro bias Kalman tracker.
// No dependencies; imported by gyro_bias_kalman_tracker_top.
`default_nettype none

package gbkt_pkg;

  // Data formats
  localparam int DATA_W        = 32;   // signed Q11.F samples and offsets
  localparam int CNT_W         = 10;   // window sample count
  localparam int SUM_W         = 43;   // window sum, holds 1024 full-scale samples
  localparam int NOISE_W       = 28;   // unsigned Q8.F noise terms
  localparam int THR_W         = 20;   // stillness threshold
  localparam int NUM_AXES      = 2;
  localparam int FRAC_BITS_DEF = 20;

  // Stream and APB widths
  localparam int TDATA_IN_W  = 6 * DATA_W;
  localparam int TUSER_IN_W  = 2;
  localparam int TDATA_OUT_W = 4 * DATA_W;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  // Register map, byte address = 4 * index
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_GYRO_X_INIT  = 3'd0;
  localparam reg_idx_t REG_GYRO_Y_INIT  = 3'd1;
  localparam reg_idx_t REG_ANGLE_X_TGT  = 3'd2;
  localparam reg_idx_t REG_ANGLE_Y_TGT  = 3'd3;
  localparam reg_idx_t REG_WINDOW_LIMIT = 3'd4;
  localparam reg_idx_t REG_PROC_NOISE   = 3'd5;
  localparam reg_idx_t REG_MEAS_NOISE   = 3'd6;
  localparam reg_idx_t REG_STILL_THR    = 3'd7;

  // Register reset values
  localparam logic [CNT_W-1:0]   WIN_LIMIT_RST = 10'd200;
  localparam logic [NOISE_W-1:0] PNOISE_RST    = 28'd1048576;
  localparam logic [NOISE_W-1:0] MNOISE_RST    = 28'd12582912;
  localparam logic [THR_W-1:0]   STILL_THR_RST = 20'd55;

  // Per-axis gyro offsets (first memory)
  typedef struct packed {
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] now;
  } gyro_state_t;

  // Per-axis window, variance, angle offset and last estimate (second memory)
  typedef struct packed {
    logic [DATA_W-1:0] prev_est;
    logic [DATA_W-1:0] variance;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] angle_now;
  } axis_state_t;

endpackage

`default_nettype wire

// ===== design/gbkt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the per-axis state of the gyro bias tracker.
`default_nettype none

module gbkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/gyro_bias_kalman_tracker_top.sv =====
// Top level of the two-axis gyro bias tracker with scalar Kalman bias update.
// Depends on gbkt_pkg and gbkt_ram.
//
// Usage:
//  - in_* stream: one IMU sample per transaction (angles, gyro rates, filtered
//    angles in tdata, foot contact flags in tuser). out_* stream: one result
//    per sample with the corrected angles and gyro rates.
//  - cfg_* APB port: eight registers at 4*index; the user must write them only
//    while idle, the block does not enforce it.
//  - A sequencer handles X then Y for each sample; per axis the state entry is
//    read from RAM, updated and written back before the other entry is touched.
//  - An axis whose window completes also runs the shared bit-serial divider
//    (43 steps for the window average, 32 + FRACTION_BITS steps for the Kalman
//    gain).
//  - One sample is in work at a time; in_tready is high in the idle state. The
//    next sample is taken while the previous result waits in the output register.
//  - When out_tready is low the finished result is held in the output register,
//    and a following sample stops before its result stage until it is taken.
//  - Reset (synchronous, rst_n low) loads register defaults and marks both RAM
//    entries invalid; invalid entries read as zero, so no clearing pass is needed.
`default_nettype none

module gyro_bias_kalman_tracker_top #(
  parameter int FRACTION_BITS = gbkt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // sample stream in
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // raw_angle_x, raw_angle_y, raw_gyro_x, raw_gyro_y, estimated_angle_x,
  // estimated_angle_y (32 bits each, lowest first)
  input  wire logic [gbkt_pkg::TDATA_IN_W-1:0]    in_tdata,
  // [0] left_foot_contact, [1] right_foot_contact
  input  wire logic [gbkt_pkg::TUSER_IN_W-1:0]    in_tuser,
  // result stream out
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // corrected_angle_x, corrected_angle_y, corrected_gyro_x, corrected_gyro_y
  // (32 bits each, lowest first)
  output logic [gbkt_pkg::TDATA_OUT_W-1:0]        out_tdata,
  // configuration
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [gbkt_pkg::CFG_AW-1:0]        cfg_paddr,
  input  wire logic [gbkt_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [gbkt_pkg::CFG_DW-1:0]             cfg_prdata,
  output logic                                    cfg_pready
);

  import gbkt_pkg::*;

  // Arithmetic widths
  localparam int DIV_W    = 64;
  localparam int REM_W    = 34;
  localparam int DVS_W    = 33;
  localparam int STEP_W   = 7;
  localparam int AvgSteps = SUM_W;
  localparam int KSteps   = DATA_W + FRACTION_BITS;
  localparam int P1W      = FRACTION_BITS + 36;
  localparam int P2W      = FRACTION_BITS + 33;
  localparam int SPW      = FRACTION_BITS + 34;
  localparam int SAT_W    = 40;
  localparam int HalfI    = 1 << (FRACTION_BITS - 1);
  localparam logic [FRACTION_BITS:0]   OneK  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [FRACTION_BITS-1:0] SlewQ =
    FRACTION_BITS'(((64'd3 << FRACTION_BITS) + 64'd50) / 64'd100);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_ACC, S_DIV0, S_DAVG, S_KSET, S_DK,
    S_MUL, S_UPD, S_SLW1, S_SLW2, S_WB, S_OUT
  } state_t;

  // Saturate to signed 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFF_FFFF);
    lo = SAT_W'($signed(32'h8000_0000));
    if (v > hi) begin
      return 32'h7FFF_FFFF;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  state_t                    state_r;
  logic                      axis_r;
  logic                      out_valid_r;
  logic [TDATA_OUT_W-1:0]    out_data_r;
  logic [NUM_AXES-1:0]       val_a_r;
  logic [NUM_AXES-1:0]       val_b_r;

  // configuration registers
  logic signed [DATA_W-1:0]  gyro_init_r [NUM_AXES];
  logic signed [DATA_W-1:0]  ang_tgt_r   [NUM_AXES];
  logic [CNT_W-1:0]          win_lim_r;
  logic [NOISE_W-1:0]        pnoise_r;
  logic [NOISE_W-1:0]        mnoise_r;
  logic [THR_W-1:0]          still_thr_r;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  // captured sample
  logic signed [DATA_W-1:0]  ang_in_r [NUM_AXES];
  logic signed [DATA_W-1:0]  gyr_in_r [NUM_AXES];
  logic signed [DATA_W-1:0]  est_in_r [NUM_AXES];
  logic                      contact_r;

  // working copy of one axis entry
  logic signed [DATA_W-1:0]  gnow_r;
  logic signed [DATA_W-1:0]  gtgt_r;
  logic signed [DATA_W-1:0]  anow_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [DATA_W-1:0]         var_r;
  logic signed [DATA_W:0]    d_r;
  logic signed [DATA_W:0]    avg_r;
  logic [DATA_W-1:0]         v_r;
  logic signed [DATA_W+1:0]  diff_r;
  logic [FRACTION_BITS:0]    k_r;
  logic signed [P1W-1:0]     prod1_r;
  logic [P2W-1:0]            prod2_r;
  logic signed [SPW-1:0]     gprod_r;
  logic signed [SPW-1:0]     aprod_r;
  logic [DATA_W-1:0]         res_ang_r [NUM_AXES];
  logic [DATA_W-1:0]         res_gyr_r [NUM_AXES];

  // memories
  logic                      ram_a_we;
  logic                      ram_a_waddr;
  gyro_state_t               ram_a_wdata;
  logic [$bits(gyro_state_t)-1:0] ram_a_q;
  logic                      ram_b_we;
  axis_state_t               ram_b_wdata;
  logic [$bits(axis_state_t)-1:0] ram_b_q;
  gyro_state_t               gyro_rd;
  axis_state_t               state_rd;

  // datapath next values
  logic signed [DATA_W-1:0]  est_cur;
  logic signed [DATA_W-1:0]  gyr_cur;
  logic signed [DATA_W-1:0]  ang_cur;
  logic signed [DATA_W-1:0]  atgt_cur;
  logic signed [DATA_W:0]    d_nxt;
  logic [DATA_W:0]           mag;
  logic signed [DATA_W:0]    obs;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic                      still;
  logic                      fire;
  logic [SUM_W-1:0]          sum_mag;
  logic [CNT_W:0]            n_win;
  logic [DATA_W-1:0]         v_sum;
  logic [DATA_W:0]           den;
  logic signed [DATA_W:0]    quo_avg;
  logic signed [DATA_W+1:0]  diff_nxt;
  logic signed [P1W-1:0]     prod1_nxt;
  logic [P2W-1:0]            prod2_nxt;
  logic signed [P1W-1:0]     rnd1;
  logic [DATA_W-1:0]         gtgt_nxt;
  logic [DATA_W-1:0]         var_nxt;
  logic signed [DATA_W:0]    gdiff;
  logic signed [DATA_W:0]    adiff;
  logic signed [SPW-1:0]     gprod_nxt;
  logic signed [SPW-1:0]     aprod_nxt;
  logic signed [SPW-1:0]     rnd_g;
  logic signed [SPW-1:0]     rnd_a;
  logic [DATA_W-1:0]         gnow_nxt;
  logic [DATA_W-1:0]         anow_nxt;
  logic [DATA_W-1:0]         ang_out;
  logic [DATA_W-1:0]         gyr_out;

  // shared divider
  logic                      div_start;
  logic [DIV_W-1:0]          div_dvd_in;
  logic [DVS_W-1:0]          div_dvs_in;
  logic [STEP_W-1:0]         div_steps;
  logic [STEP_W-1:0]         div_cnt_r;
  logic [REM_W-1:0]          div_rem_r;
  logic [DIV_W-1:0]          div_dvd_r;
  logic [DIV_W-1:0]          div_quo_r;
  logic [DVS_W-1:0]          div_dvs_r;
  logic [REM_W-1:0]          rem_sh;
  logic                      rem_ge;
  logic                      div_done;
  logic                      out_load;
  logic                      out_valid_nxt;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_tready     = (state_r == S_IDLE);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_load      = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_init_r[0] <= '0;
      gyro_init_r[1] <= '0;
      ang_tgt_r[0]   <= '0;
      ang_tgt_r[1]   <= '0;
      win_lim_r      <= WIN_LIMIT_RST;
      pnoise_r       <= PNOISE_RST;
      mnoise_r       <= MNOISE_RST;
      still_thr_r    <= STILL_THR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GYRO_X_INIT:  gyro_init_r[0] <= cfg_pwdata;
        REG_GYRO_Y_INIT:  gyro_init_r[1] <= cfg_pwdata;
        REG_ANGLE_X_TGT:  ang_tgt_r[0]   <= cfg_pwdata;
        REG_ANGLE_Y_TGT:  ang_tgt_r[1]   <= cfg_pwdata;
        REG_WINDOW_LIMIT: win_lim_r      <= cfg_pwdata[CNT_W-1:0];
        REG_PROC_NOISE:   pnoise_r       <= cfg_pwdata[NOISE_W-1:0];
        REG_MEAS_NOISE:   mnoise_r       <= cfg_pwdata[NOISE_W-1:0];
        REG_STILL_THR:    still_thr_r    <= cfg_pwdata[THR_W-1:0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_GYRO_X_INIT:  cfg_prdata = gyro_init_r[0];
      REG_GYRO_Y_INIT:  cfg_prdata = gyro_init_r[1];
      REG_ANGLE_X_TGT:  cfg_prdata = ang_tgt_r[0];
      REG_ANGLE_Y_TGT:  cfg_prdata = ang_tgt_r[1];
      REG_WINDOW_LIMIT: cfg_prdata = CFG_DW'(win_lim_r);
      REG_PROC_NOISE:   cfg_prdata = CFG_DW'(pnoise_r);
      REG_MEAS_NOISE:   cfg_prdata = CFG_DW'(mnoise_r);
      REG_STILL_THR:    cfg_prdata = CFG_DW'(still_thr_r);
    endcase
  end

  // ---------------------------------------------------------------------------
  // State memories: gyro offsets, and the rest of the axis state
  // ---------------------------------------------------------------------------
  // gyro entry is written back per sample, or loaded by a gyro init write
  always_comb begin
    ram_a_we           = 1'b0;
    ram_a_waddr        = axis_r;
    ram_a_wdata.target = gtgt_r;
    ram_a_wdata.now    = gnow_r;
    if (state_r == S_WB) begin
      ram_a_we = 1'b1;
    end else if (cfg_wr && (cfg_idx == REG_GYRO_X_INIT || cfg_idx == REG_GYRO_Y_INIT)) begin
      ram_a_we           = 1'b1;
      ram_a_waddr        = cfg_idx[0];
      ram_a_wdata.target = cfg_pwdata;
      ram_a_wdata.now    = cfg_pwdata;
    end
  end

  assign ram_b_we              = (state_r == S_WB);
  assign ram_b_wdata.prev_est  = est_cur;
  assign ram_b_wdata.variance  = var_r;
  assign ram_b_wdata.sum       = sum_r;
  assign ram_b_wdata.count     = cnt_r;
  assign ram_b_wdata.angle_now = anow_r;

  gbkt_ram #(
    .WIDTH ($bits(gyro_state_t)),
    .DEPTH (NUM_AXES)
  ) u_gyro_ram (
    .clk   (clk),
    .we    (ram_a_we),
    .waddr (ram_a_waddr),
    .wdata (ram_a_wdata),
    .raddr (axis_r),
    .rdata (ram_a_q)
  );

  gbkt_ram #(
    .WIDTH ($bits(axis_state_t)),
    .DEPTH (NUM_AXES)
  ) u_axis_ram (
    .clk   (clk),
    .we    (ram_b_we),
    .waddr (axis_r),
    .wdata (ram_b_wdata),
    .raddr (axis_r),
    .rdata (ram_b_q)
  );

  // entries never written since reset read as zero
  assign gyro_rd  = val_a_r[axis_r] ? gyro_state_t'(ram_a_q) : '0;
  assign state_rd = val_b_r[axis_r] ? axis_state_t'(ram_b_q) : '0;

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  assign est_cur  = est_in_r[axis_r];
  assign gyr_cur  = gyr_in_r[axis_r];
  assign ang_cur  = ang_in_r[axis_r];
  assign atgt_cur = ang_tgt_r[axis_r];

  // angle change since previous sample
  assign d_nxt = (DATA_W+1)'(est_cur) - (DATA_W+1)'($signed(state_rd.prev_est));
  assign mag   = d_r[DATA_W] ? (-d_r) : d_r;

  // stillness test and window accumulate
  assign obs     = -((DATA_W+1)'(gyr_cur));
  assign sum_nxt = sum_r + SUM_W'(obs);
  assign still   = contact_r && (mag <= (DATA_W+1)'(still_thr_r));
  assign fire    = still && (cnt_r >= win_lim_r);

  // divider operands
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign n_win   = (CNT_W+1)'(cnt_r) + (CNT_W+1)'(1);
  assign v_sum   = var_r + DATA_W'(pnoise_r);
  assign den     = (DATA_W+1)'(v_sum) + (DATA_W+1)'(mnoise_r);
  assign quo_avg = $signed({1'b0, div_quo_r[DATA_W-1:0]});

  // Kalman update
  assign diff_nxt  = (DATA_W+2)'(avg_r) - (DATA_W+2)'(gtgt_r);
  assign prod1_nxt = diff_r * $signed({1'b0, k_r});
  assign prod2_nxt = P2W'(OneK - k_r) * P2W'(v_r);
  assign rnd1      = (prod1_r + P1W'(HalfI)) >>> FRACTION_BITS;
  assign gtgt_nxt  = sat32(SAT_W'(gtgt_r) + SAT_W'(rnd1));
  assign var_nxt   = DATA_W'((prod2_r + P2W'(HalfI)) >> FRACTION_BITS);

  // offset slews
  assign gdiff     = (DATA_W+1)'(gtgt_r) - (DATA_W+1)'(gnow_r);
  assign adiff     = (DATA_W+1)'(atgt_cur) - (DATA_W+1)'(anow_r);
  assign gprod_nxt = gdiff * $signed({1'b0, SlewQ});
  assign aprod_nxt = adiff * $signed({1'b0, SlewQ});
  assign rnd_g     = (gprod_r + SPW'(HalfI)) >>> FRACTION_BITS;
  assign rnd_a     = (aprod_r + SPW'(HalfI)) >>> FRACTION_BITS;
  assign gnow_nxt  = sat32(SAT_W'(gnow_r) + SAT_W'(rnd_g));
  assign anow_nxt  = sat32(SAT_W'(anow_r) + SAT_W'(rnd_a));

  // corrected outputs
  assign ang_out = sat32(SAT_W'(ang_cur) + SAT_W'(anow_r));
  assign gyr_out = sat32(SAT_W'(gyr_cur) + SAT_W'(gnow_r));

  // ---------------------------------------------------------------------------
  // Shared restoring divider, one quotient bit per cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    div_start  = 1'b0;
    div_dvd_in = '0;
    div_dvs_in = '0;
    div_steps  = '0;
    unique case (state_r)
      S_DIV0: begin
        div_start  = 1'b1;
        div_dvd_in = {sum_mag, (DIV_W-SUM_W)'(0)};
        div_dvs_in = DVS_W'(n_win);
        div_steps  = STEP_W'(AvgSteps);
      end
      S_KSET: begin
        div_start  = (den != '0);
        div_dvd_in = {v_sum, (DIV_W-DATA_W)'(0)};
        div_dvs_in = den;
        div_steps  = STEP_W'(KSteps);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign rem_sh   = {div_rem_r[REM_W-2:0], div_dvd_r[DIV_W-1]};
  assign rem_ge   = (rem_sh >= REM_W'(div_dvs_r));
  assign div_done = (div_cnt_r == '0);

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_cnt_r <= div_steps;
    end else if (!div_done) begin
      div_cnt_r <= div_cnt_r - STEP_W'(1);
    end
  end

  // remainder, dividend and quotient shift registers
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem_r <= '0;
      div_dvd_r <= div_dvd_in;
      div_quo_r <= '0;
      div_dvs_r <= div_dvs_in;
    end else if (!div_done) begin
      div_rem_r <= rem_ge ? (rem_sh - REM_W'(div_dvs_r)) : rem_sh;
      div_dvd_r <= {div_dvd_r[DIV_W-2:0], 1'b0};
      div_quo_r <= {div_quo_r[DIV_W-2:0], rem_ge};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: state, axis select, valid bits and output register control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      val_a_r     <= '0;
      val_b_r     <= '0;
    end else begin
      if (ram_a_we) begin
        val_a_r[ram_a_waddr] <= 1'b1;
      end
      if (ram_b_we) begin
        val_b_r[axis_r] <= 1'b1;
      end
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            axis_r  <= 1'b0;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_LOAD;
        S_LOAD: state_r <= S_ACC;
        S_ACC:  state_r <= fire ? S_DIV0 : S_SLW1;
        S_DIV0: state_r <= S_DAVG;
        S_DAVG: begin
          if (div_done) begin
            state_r <= S_KSET;
          end
        end
        S_KSET: state_r <= (den == '0) ? S_MUL : S_DK;
        S_DK: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL:  state_r <= S_UPD;
        S_UPD:  state_r <= S_SLW1;
        S_SLW1: state_r <= S_SLW2;
        S_SLW2: state_r <= S_WB;
        S_WB: begin
          if (!axis_r) begin
            axis_r  <= 1'b1;
            state_r <= S_READ;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // capture the sample on its transaction
    if (in_tvalid && in_tready) begin
      ang_in_r[0] <= in_tdata[31:0];
      ang_in_r[1] <= in_tdata[63:32];
      gyr_in_r[0] <= in_tdata[95:64];
      gyr_in_r[1] <= in_tdata[127:96];
      est_in_r[0] <= in_tdata[159:128];
      est_in_r[1] <= in_tdata[191:160];
      contact_r   <= in_tuser[0] || in_tuser[1];
    end

    if (out_load) begin
      out_data_r <= {res_gyr_r[1], res_gyr_r[0], res_ang_r[1], res_ang_r[0]};
    end

    unique case (state_r)
      // load working copy of the axis entry
      S_LOAD: begin
        gnow_r <= gyro_rd.now;
        gtgt_r <= gyro_rd.target;
        anow_r <= state_rd.angle_now;
        cnt_r  <= state_rd.count;
        sum_r  <= state_rd.sum;
        var_r  <= state_rd.variance;
        d_r    <= d_nxt;
      end
      // accumulate a still sample; the count restarts after an update
      S_ACC: begin
        if (still) begin
          sum_r <= sum_nxt;
          if (!fire) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
      end
      // window average, truncated toward zero
      S_DAVG: begin
        if (div_done) begin
          avg_r <= sum_r[SUM_W-1] ? -quo_avg : quo_avg;
        end
      end
      S_KSET: begin
        v_r    <= v_sum;
        diff_r <= diff_nxt;
        if (den == '0) begin
          k_r <= '0;
        end
      end
      S_DK: begin
        if (div_done) begin
          k_r <= div_quo_r[FRACTION_BITS:0];
        end
      end
      S_MUL: begin
        prod1_r <= prod1_nxt;
        prod2_r <= prod2_nxt;
      end
      S_UPD: begin
        gtgt_r <= gtgt_nxt;
        var_r  <= var_nxt;
        cnt_r  <= '0;
        sum_r  <= '0;
      end
      S_SLW1: begin
        gprod_r <= gprod_nxt;
        aprod_r <= aprod_nxt;
      end
      S_SLW2: begin
        gnow_r <= gnow_nxt;
        anow_r <= anow_nxt;
      end
      // corrected values for this axis
      S_WB: begin
        res_ang_r[axis_r] <= ang_out;
        res_gyr_r[axis_r] <= gyr_out;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
